// ----- rtl/cffsa_pkg.sv -----
// Package for the circular first-free slot allocator.
// Holds field widths, status codes and the command and status types between controller and datapath.
// No dependencies.
package cffsa_pkg;

  localparam int unsigned SLOTS_DEF   = 1024;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned SLOT_W      = 11;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned TDATA_W     = 16;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLR_INIT,
    CMD_CLR_LEAF,
    CMD_CLR_READ,
    CMD_CLR_WRITE,
    CMD_LOAD,
    CMD_Q_STEP,
    CMD_Q_DRAIN,
    CMD_ROOT_READ,
    CMD_ROOT_USE,
    CMD_UPD_LEAF,
    CMD_UPD_STEP,
    CMD_RESULT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    upd_free;   // leaf update frees the slot (release) instead of taking it
  } dp_cmd_t;

  typedef struct packed {
    logic clr_leaf_last;  // clearing pass is at the lowest leaf
    logic clr_last;       // clearing pass is at the root
    logic q_active;       // range walk still has nodes to visit
    logic found;          // best candidate is a free slot
    logic bad_slot;       // slot number outside 1..count
    logic is_release;     // current item frees a slot
    logic upd_last;       // path repair is at the root
    logic out_free;       // output register can take a result
  } dp_status_t;

endpackage

// ----- rtl/cffsa_ctrl.sv -----
// Controller state machine of the circular first-free slot allocator.
// Sequences clearing, range queries and path repair; depends on cffsa_pkg.
module cffsa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cffsa_pkg::dp_status_t sts_i,
  output cffsa_pkg::dp_cmd_t    cmd_o
);

  localparam logic [3:0] ST_CLR_INIT = 4'd0;
  localparam logic [3:0] ST_CLR_LEAF = 4'd1;
  localparam logic [3:0] ST_CLR_RD   = 4'd2;
  localparam logic [3:0] ST_CLR_WR   = 4'd3;
  localparam logic [3:0] ST_IDLE     = 4'd4;
  localparam logic [3:0] ST_DECODE   = 4'd5;
  localparam logic [3:0] ST_QUERY    = 4'd6;
  localparam logic [3:0] ST_QCHECK   = 4'd7;
  localparam logic [3:0] ST_ROOT     = 4'd8;
  localparam logic [3:0] ST_RCHECK   = 4'd9;
  localparam logic [3:0] ST_UPD      = 4'd10;
  localparam logic [3:0] ST_RESULT   = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o.op       = cffsa_pkg::CMD_NONE;
    cmd_o.upd_free = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_CLR_INIT: begin
        cmd_o.op = cffsa_pkg::CMD_CLR_INIT;
        state_d  = ST_CLR_LEAF;
      end
      ST_CLR_LEAF: begin
        cmd_o.op = cffsa_pkg::CMD_CLR_LEAF;
        if (sts_i.clr_leaf_last) begin
          state_d = ST_CLR_RD;
        end
      end
      ST_CLR_RD: begin
        cmd_o.op = cffsa_pkg::CMD_CLR_READ;
        state_d  = ST_CLR_WR;
      end
      ST_CLR_WR: begin
        cmd_o.op = cffsa_pkg::CMD_CLR_WRITE;
        state_d  = sts_i.clr_last ? ST_IDLE : ST_CLR_RD;
      end
      ST_IDLE: begin
        in_ready_o = !cfg_we_i;
        if (in_valid_i && !cfg_we_i) begin
          cmd_o.op = cffsa_pkg::CMD_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.bad_slot) begin
          state_d = ST_RESULT;
        end else if (sts_i.is_release) begin
          cmd_o.op       = cffsa_pkg::CMD_UPD_LEAF;
          cmd_o.upd_free = 1'b1;
          state_d        = ST_UPD;
        end else begin
          state_d = ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (sts_i.q_active) begin
          cmd_o.op = cffsa_pkg::CMD_Q_STEP;
        end else begin
          cmd_o.op = cffsa_pkg::CMD_Q_DRAIN;
          state_d  = ST_QCHECK;
        end
      end
      ST_QCHECK: begin
        if (sts_i.found) begin
          cmd_o.op = cffsa_pkg::CMD_UPD_LEAF;
          state_d  = ST_UPD;
        end else begin
          cmd_o.op = cffsa_pkg::CMD_ROOT_READ;
          state_d  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.op = cffsa_pkg::CMD_ROOT_USE;
        state_d  = ST_RCHECK;
      end
      ST_RCHECK: begin
        if (sts_i.found) begin
          cmd_o.op = cffsa_pkg::CMD_UPD_LEAF;
          state_d  = ST_UPD;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_UPD: begin
        cmd_o.op = cffsa_pkg::CMD_UPD_STEP;
        if (sts_i.upd_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.op = cffsa_pkg::CMD_RESULT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLR_INIT;
      end
    endcase
    // a new count restarts the clearing pass
    if (cfg_we_i) begin
      state_d = ST_CLR_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/cffsa_dpath.sv -----
// Datapath of the circular first-free slot allocator: min-tree memory, walk registers,
// count register and output register. Depends on cffsa_pkg; driven by cffsa_ctrl.
module cffsa_dpath #(
  parameter int unsigned SLOTS = cffsa_pkg::SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cffsa_pkg::dp_cmd_t                 cmd_i,
  output cffsa_pkg::dp_status_t              sts_o,
  input  logic                               cfg_we_i,
  input  logic [cffsa_pkg::COUNT_W-1:0]      cfg_wdata_i,
  input  logic                               in_mode_i,
  input  logic [cffsa_pkg::SLOT_W-1:0]       in_slot_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [cffsa_pkg::SLOT_W-1:0]       out_granted_o,
  output logic [cffsa_pkg::STATUS_W-1:0]     out_status_o,
  output logic [$clog2(SLOTS+1)-1:0]         live_count_o
);

  localparam int unsigned NW    = $clog2(SLOTS + 1);     // node value, SLOTS is "none"
  localparam int unsigned AW    = $clog2(2 * SLOTS);     // node address
  localparam int unsigned QW    = $clog2(2 * SLOTS + 1); // walk bounds reach 2*SLOTS
  localparam int unsigned DEPTH = 2 * SLOTS;
  localparam logic [NW-1:0] NONE = NW'(SLOTS);

  // tree memory, root at node 1, leaf i at node SLOTS+i
  logic [NW-1:0] tree_mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [NW-1:0] mem_wdata, rd_a_q, rd_b_q;

  logic [cffsa_pkg::COUNT_W-1:0]  slot_count_q, slot_count_d;
  logic                           mode_q, mode_d;
  logic [cffsa_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [QW-1:0]                  l_q, l_d, r_q, r_d;
  logic                           pend_a_q, pend_a_d, pend_b_q, pend_b_d;
  logic [NW-1:0]                  best_q, best_d, val_q, val_d, acc, leaf_val, step_val;
  logic [AW-1:0]                  node_q, node_d, leaf_addr;
  logic [NW-1:0]                  live, clr_idx, leaf_idx;
  logic                           bad;
  logic                           out_valid_q, out_valid_d;
  logic [cffsa_pkg::SLOT_W-1:0]   out_granted_q, out_granted_d;
  logic [cffsa_pkg::STATUS_W-1:0] out_status_q, out_status_d;

  function automatic logic [NW-1:0] min_node(input logic [NW-1:0] a, input logic [NW-1:0] b);
    min_node = (a < b) ? a : b;
  endfunction

  assign live = (32'(slot_count_q) > SLOTS) ? NONE : NW'(slot_count_q);
  assign bad  = (slot_q == '0) || (32'(slot_q) > 32'(live));
  assign live_count_o = live;

  assign clr_idx   = NW'(node_q - AW'(SLOTS));
  assign leaf_idx  = cmd_i.upd_free ? NW'(slot_q - 1'b1) : best_q;
  assign leaf_addr = AW'(SLOTS) + AW'(leaf_idx);
  assign leaf_val  = cmd_i.upd_free ? leaf_idx : NONE;
  assign step_val  = min_node(val_q, rd_a_q);

  // fold in the nodes read by the previous walk step
  always_comb begin
    acc = best_q;
    if (pend_a_q) begin
      acc = min_node(acc, rd_a_q);
    end
    if (pend_b_q) begin
      acc = min_node(acc, rd_b_q);
    end
  end

  always_comb begin
    slot_count_d  = cfg_we_i ? cfg_wdata_i : slot_count_q;
    mode_d        = mode_q;
    slot_d        = slot_q;
    l_d           = l_q;
    r_d           = r_q;
    pend_a_d      = pend_a_q;
    pend_b_d      = pend_b_q;
    best_d        = best_q;
    val_d         = val_q;
    node_d        = node_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_granted_d = out_granted_q;
    out_status_d  = out_status_q;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr_a   = '0;
    mem_raddr_b   = '0;
    unique case (cmd_i.op)
      cffsa_pkg::CMD_NONE: begin
      end
      cffsa_pkg::CMD_CLR_INIT: begin
        node_d = AW'(DEPTH - 1);
      end
      cffsa_pkg::CMD_CLR_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = node_q;
        mem_wdata = (clr_idx < live) ? clr_idx : NONE;
        node_d    = node_q - 1'b1;
      end
      cffsa_pkg::CMD_CLR_READ: begin
        mem_raddr_a = {node_q[AW-2:0], 1'b0};
        mem_raddr_b = {node_q[AW-2:0], 1'b1};
      end
      cffsa_pkg::CMD_CLR_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = node_q;
        mem_wdata = min_node(rd_a_q, rd_b_q);
        node_d    = node_q - 1'b1;
      end
      cffsa_pkg::CMD_LOAD: begin
        mode_d   = in_mode_i;
        slot_d   = in_slot_i;
        l_d      = QW'(SLOTS) + QW'(in_slot_i) - 1'b1;
        r_d      = QW'(DEPTH);
        pend_a_d = 1'b0;
        pend_b_d = 1'b0;
        best_d   = NONE;
      end
      cffsa_pkg::CMD_Q_STEP: begin
        best_d      = acc;
        mem_raddr_a = l_q[AW-1:0];
        mem_raddr_b = AW'(r_q - 1'b1);
        pend_a_d    = l_q[0];
        pend_b_d    = r_q[0];
        l_d         = (l_q + QW'(l_q[0])) >> 1;
        r_d         = (r_q - QW'(r_q[0])) >> 1;
      end
      cffsa_pkg::CMD_Q_DRAIN: begin
        best_d   = acc;
        pend_a_d = 1'b0;
        pend_b_d = 1'b0;
      end
      cffsa_pkg::CMD_ROOT_READ: begin
        mem_raddr_a = AW'(1);
      end
      cffsa_pkg::CMD_ROOT_USE: begin
        best_d = rd_a_q;
      end
      cffsa_pkg::CMD_UPD_LEAF: begin
        mem_we      = 1'b1;
        mem_waddr   = leaf_addr;
        mem_wdata   = leaf_val;
        mem_raddr_a = leaf_addr ^ AW'(1);
        node_d      = leaf_addr >> 1;
        val_d       = leaf_val;
      end
      cffsa_pkg::CMD_UPD_STEP: begin
        mem_we      = 1'b1;
        mem_waddr   = node_q;
        mem_wdata   = step_val;
        mem_raddr_a = node_q ^ AW'(1);
        node_d      = node_q >> 1;
        val_d       = step_val;
      end
      cffsa_pkg::CMD_RESULT: begin
        out_valid_d = 1'b1;
        if (bad) begin
          out_granted_d = '0;
          out_status_d  = cffsa_pkg::STATUS_RANGE;
        end else if (mode_q == cffsa_pkg::MODE_RELEASE) begin
          out_granted_d = '0;
          out_status_d  = cffsa_pkg::STATUS_OK;
        end else if (best_q != NONE) begin
          out_granted_d = cffsa_pkg::SLOT_W'(32'(best_q) + 1);
          out_status_d  = cffsa_pkg::STATUS_OK;
        end else begin
          out_granted_d = '0;
          out_status_d  = cffsa_pkg::STATUS_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= tree_mem[mem_raddr_a];
    rd_b_q <= tree_mem[mem_raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= cffsa_pkg::COUNT_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      slot_count_q <= slot_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    slot_q        <= slot_d;
    l_q           <= l_d;
    r_q           <= r_d;
    pend_a_q      <= pend_a_d;
    pend_b_q      <= pend_b_d;
    best_q        <= best_d;
    val_q         <= val_d;
    node_q        <= node_d;
    out_granted_q <= out_granted_d;
    out_status_q  <= out_status_d;
  end

  assign sts_o.clr_leaf_last = (node_q == AW'(SLOTS));
  assign sts_o.clr_last      = (node_q == AW'(1));
  assign sts_o.q_active      = (l_q < r_q);
  assign sts_o.found         = (best_q != NONE);
  assign sts_o.bad_slot      = bad;
  assign sts_o.is_release    = (mode_q == cffsa_pkg::MODE_RELEASE);
  assign sts_o.upd_last      = (node_q == AW'(1));
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_granted_o = out_granted_q;
  assign out_status_o  = out_status_q;

endmodule

// ----- rtl/circular_first_free_slot_allocator_unit.sv -----
// Top level of the circular first-free slot allocator.
// Joins cffsa_ctrl and cffsa_dpath; depends on cffsa_pkg.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata[10:0] slot, tuser[0] mode
//  m_axis    out        tvalid/tready          tdata[10:0] granted_slot, tuser[1:0] status
//  cfg       in         cfg_we_i (no wait)     cfg_wdata_i slot_count
//
// One item at a time. An allocate occupies the block from the accepting cycle through the
// result: a range walk of one tree level per cycle on the two read ports of the tree memory,
// then a read of the root when the search wraps, then a leaf-to-root repair of one level per
// cycle on its write port. A release skips the walk; a slot out of range skips both.
// Reset, and every write of slot_count, start a clearing pass that rebuilds the tree;
// s_axis_tready stays low meanwhile.
// A result waits in the output register while m_axis_tready is low; the next item is
// still accepted and stalls only when its own result finds the register occupied.
module circular_first_free_slot_allocator_unit #(
  parameter int unsigned SLOTS = cffsa_pkg::SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: slot_count
  input  logic                               cfg_we_i,
  input  logic [cffsa_pkg::COUNT_W-1:0]      cfg_wdata_i,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cffsa_pkg::TDATA_W-1:0]      s_axis_tdata,  // [10:0] slot, [15:11] zero
  input  logic [0:0]                         s_axis_tuser,  // [0] mode
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [cffsa_pkg::TDATA_W-1:0]      m_axis_tdata,  // [10:0] granted_slot, [15:11] zero
  output logic [cffsa_pkg::STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);

  cffsa_pkg::dp_cmd_t             cmd;
  cffsa_pkg::dp_status_t          sts;
  logic [cffsa_pkg::SLOT_W-1:0]   granted;
  logic [$clog2(SLOTS+1)-1:0]     live_count;

  // sequence clearing, search and repair
  cffsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold the min-tree, the walk state and the result register
  cffsa_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_mode_i     (s_axis_tuser[0]),
    .in_slot_i     (s_axis_tdata[cffsa_pkg::SLOT_W-1:0]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_granted_o (granted),
    .out_status_o  (m_axis_tuser),
    .live_count_o  (live_count)
  );

  // pad the granted slot up to whole bytes
  assign m_axis_tdata = {{(cffsa_pkg::TDATA_W - cffsa_pkg::SLOT_W){1'b0}}, granted};

`ifndef SYNTHESIS
  // one item in flight: no second transfer right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted while one is in flight");

  // a failed result (full or out of range) never carries a slot number
  a_fail_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != cffsa_pkg::STATUS_OK) |-> (m_axis_tdata == '0))
    else $error("failure result carries a slot number");

  // a granted slot lies within the live count and the status code is defined
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata) <= 32'(live_count)) &&
      (m_axis_tuser == cffsa_pkg::STATUS_OK || m_axis_tuser == cffsa_pkg::STATUS_FULL ||
       m_axis_tuser == cffsa_pkg::STATUS_RANGE))
    else $error("granted slot beyond count or undefined status");
`endif

endmodule
